// ----- hw/rtl/dts_pkg.sv -----
// Shared constants, types and helpers for the diamond tile slot manager.
// No dependencies.
`default_nettype none
package dts_pkg;

    localparam int RADIUS  = 4;
    localparam int SLOTS   = 41;
    localparam int COORD_W = 16;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int SLOT_OW = 6;
    localparam int GRID    = 2 * RADIUS + 1;
    localparam int MAP_N   = GRID * GRID;
    localparam int MAP_IW  = $clog2(MAP_N);
    localparam int GRID_W  = $clog2(GRID);
    localparam int OFS_W   = $clog2(RADIUS + 1) + 1;
    localparam int ENTRY_W = 2 * COORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_DRAIN,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic               v;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SLOT_AW-1:0] slot;
    } t_push;

    // Tile offset relative to the centre -> bit of the residency map.
    function automatic logic [MAP_IW-1:0] map_idx(input logic [COORD_W-1:0] dx,
                                                  input logic [COORD_W-1:0] dy);
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        sx = dx + COORD_W'(RADIUS);
        sy = dy + COORD_W'(RADIUS);
        return MAP_IW'(MAP_IW'(sx[GRID_W-1:0]) * MAP_IW'(GRID) + MAP_IW'(sy[GRID_W-1:0]));
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dts_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module dts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 41
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dts_out.sv -----
// Result stage: holds one pending result so the final one can carry tlast,
// then an output register toward the stream. Uses dts_pkg.
`default_nettype none
module dts_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire dts_pkg::t_push              i_push,
    input  wire logic                        i_flush,
    output logic                             o_rdy,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [39:0]                      m_axis_tdata,
    output logic                             m_axis_tlast
);
    import dts_pkg::*;

    logic  r_pend_v;
    t_push r_pend;
    logic  r_out_v;
    logic  r_out_last;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [SLOT_AW-1:0] r_out_slot;
    logic  mv_ok;

    assign mv_ok = !r_out_v || m_axis_tready;
    assign o_rdy = !r_pend_v || mv_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (r_pend_v && mv_ok && (i_push.v || i_flush)) begin
                r_out_v    <= 1'b1;
                r_out_last <= i_flush;
                r_out_x    <= r_pend.x;
                r_out_y    <= r_pend.y;
                r_out_slot <= r_pend.slot;
            end
            if (i_push.v && o_rdy) begin
                r_pend_v <= 1'b1;
                r_pend   <= i_push;
            end else if (i_flush && o_rdy) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out_last;
    // tdata: tile_x [15:0], tile_y [31:16], slot [37:32], zero fill
    assign m_axis_tdata  = {2'b00, SLOT_OW'(r_out_slot), r_out_y, r_out_x};

`ifndef SYNTHESIS
    a_no_push_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.v && i_flush)) else $error("push and flush together");
    a_pend_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && !o_rdy) |=> r_pend_v) else $error("pending result lost");
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && i_flush && mv_ok) |=> (r_out_v && r_out_last))
        else $error("flush did not mark last");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/diamond_tile_slot_manager_unit.sv -----
// Diamond tile slot manager, top level: control sequencer, slot table RAM
// and used bits. Uses dts_pkg, dts_ram and dts_out.
// Per centre: a slot sweep over all SLOTS entries (S_FREE, S_DRAIN), a scan over the
// 2*RADIUS*(RADIUS+1)+1 diamond points (S_SCAN) and a flush (S_FLUSH).
// A new centre is taken only in S_IDLE, after the flush; output stalls extend the scan.
// Reset (synchronous, active low) empties all slots; RAM contents are not cleared.
`default_nettype none
module diamond_tile_slot_manager_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // centre_x [15:0], centre_y [31:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // tile_x [15:0], tile_y [31:16], slot [37:32]
    output logic             m_axis_tlast
);
    import dts_pkg::*;

    t_state r_state, n_state;
    logic [COORD_W-1:0] r_cx, r_cy;
    logic [SLOT_AW-1:0] r_k;
    logic               r_rd_v;
    logic [SLOT_AW-1:0] r_rd_k;
    logic [SLOTS-1:0]   r_used;
    logic [MAP_N-1:0]   r_map;
    logic signed [OFS_W-1:0] r_ox, r_oy;

    logic [ENTRY_W-1:0] rdata;
    logic [COORD_W-1:0] dx, dy;
    logic [COORD_W:0]   ax, ay;
    logic [COORD_W+1:0] dist_sum;
    logic               in_dia;

    logic               free_any;
    logic [SLOT_AW-1:0] free_slot;
    logic [COORD_W-1:0] ox16, oy16, tx, ty;
    logic [MAP_IW-1:0]  pidx;
    logic               step, assign_en, scan_end;
    logic signed [OFS_W-1:0] yr, nox, noy_abs;
    t_push              push;
    logic               flush, out_rdy, accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Sweep check: is the resident tile still inside the new diamond?
    assign dx   = rdata[COORD_W-1:0] - r_cx;
    assign dy   = rdata[ENTRY_W-1:COORD_W] - r_cy;
    assign ax   = dx[COORD_W-1] ? -{1'b1, dx} : {1'b0, dx};
    assign ay   = dy[COORD_W-1] ? -{1'b1, dy} : {1'b0, dy};
    assign dist_sum = {1'b0, ax} + {1'b0, ay};
    assign in_dia = dist_sum <= (COORD_W+2)'(RADIUS);

    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_any  = 1'b1;
                free_slot = SLOT_AW'(k);
            end
        end
    end

    // Scan point
    assign ox16 = {{(COORD_W-OFS_W){r_ox[OFS_W-1]}}, r_ox};
    assign oy16 = {{(COORD_W-OFS_W){r_oy[OFS_W-1]}}, r_oy};
    assign tx   = r_cx + ox16;
    assign ty   = r_cy + oy16;
    assign pidx = map_idx(ox16, oy16);
    assign yr   = OFS_W'(RADIUS) - (r_ox < 0 ? -r_ox : r_ox);
    assign nox  = r_ox + OFS_W'(1);
    assign noy_abs = OFS_W'(RADIUS) - (nox < 0 ? -nox : nox);
    assign scan_end = (r_oy == yr) && (r_ox == OFS_W'(RADIUS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_FREE;
            S_FREE:  if (r_k == SLOT_AW'(SLOTS - 1)) n_state = S_DRAIN;
            S_DRAIN: n_state = S_SCAN;
            S_SCAN:  if (step && scan_end) n_state = S_FLUSH;
            S_FLUSH: if (out_rdy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        step      = 1'b0;
        assign_en = 1'b0;
        flush     = 1'b0;
        case (r_state)
            S_SCAN: begin
                step      = out_rdy;
                assign_en = out_rdy && !r_map[pidx] && free_any;
            end
            S_FLUSH: flush = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        push.v    = assign_en;
        push.x    = tx;
        push.y    = ty;
        push.slot = free_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == S_FREE);
            if (r_rd_v && r_used[r_rd_k] && !in_dia) begin
                r_used[r_rd_k] <= 1'b0;
            end
            if (assign_en) begin
                r_used[free_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        if (accept) begin
            r_cx <= s_axis_tdata[15:0];
            r_cy <= s_axis_tdata[31:16];
            r_k  <= '0;
            r_map <= '0;
            r_ox <= -OFS_W'(RADIUS);
            r_oy <= '0;
        end else begin
            if (r_state == S_FREE) begin
                r_k <= r_k + SLOT_AW'(1);
            end
            if (r_rd_v && r_used[r_rd_k] && in_dia) begin
                r_map[map_idx(dx, dy)] <= 1'b1;
            end
            if (step && !scan_end) begin
                if (r_oy == yr) begin
                    r_ox <= nox;
                    r_oy <= -noy_abs;
                end else begin
                    r_oy <= r_oy + OFS_W'(1);
                end
            end
        end
    end

    // Sweep reads and scan writes never share a phase, so no forwarding.
    dts_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (assign_en),
        .i_waddr (free_slot),
        .i_wdata ({ty, tx}),
        .i_raddr (r_k),
        .o_rdata (rdata)
    );

    dts_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_flush       (flush),
        .o_rdy         (out_rdy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !assign_en) else $error("assignment while idle");
    a_assign_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        assign_en |=> r_used[$past(free_slot)]) else $error("slot not marked used");
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |-> (r_k < SLOT_AW'(SLOTS))) else $error("sweep overran");
`endif

endmodule
`default_nettype wire
